/* hdl/deq_pkg.sv */
// shared types and constants for the double-ended queue
// no dependencies; imported by deq_ram and double_ended_queue_top
package deq_pkg;

    localparam int DEQ_DEPTH = 16;
    localparam int CMD_W     = 3;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

/* hdl/deq_ram.sv */
// ring store of the queue: one port, synchronous write, registered read
// depends on deq_pkg
module deq_ram #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                               clk,
    input  deq_pkg::mem_ctl_t                  ctl,
    input  logic [$clog2(DEPTH)-1:0]           addr,
    input  logic signed [deq_pkg::DATA_W-1:0]  wdata,
    output logic signed [deq_pkg::DATA_W-1:0]  rdata
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/double_ended_queue_top.sv */
// Double-ended queue of signed 32-bit words in a DEPTH-entry ring store. Every command
// (push/pop/peek at either end) gives exactly one result word, held in a pending stage
// and then the output register, and a new command can be taken every cycle while the
// output side keeps up: each command makes at most one access to the single-port store,
// whose registered read feeds the output register from the pending stage. Pushes on a
// full queue and pops or peeks on an empty one return ok low and leave the queue
// unchanged. No clearing pass is needed after reset. Depends on deq_pkg and deq_ram.
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [deq_pkg::CMD_W-1:0]           cmd,
    input  logic signed [deq_pkg::DATA_W-1:0]   data_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic signed [deq_pkg::DATA_W-1:0]   data_out,
    output logic [deq_pkg::COUNT_W-1:0]         count,
    output logic                                empty_res,
    output logic                                full_res
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

    // queue state
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // word waiting on the store read
    logic             pend_reg, pend_next;
    logic             pend_ok_reg, pend_ok_next;
    logic             pend_peek_reg, pend_peek_next;
    logic [CNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    // output word
    logic                    out_valid_reg, out_valid_next;
    logic                    ok_reg;
    logic signed [DATA_W-1:0] data_out_reg;
    logic [CNT_W-1:0]        cnt_out_reg;

    logic                    accept;
    logic                    pend_move;
    logic                    is_empty;
    logic                    is_full;
    logic                    ok_c;
    logic                    peek_c;
    logic                    back_c;
    mem_ctl_t                mem_ctl;
    logic [PTR_W-1:0]        addr_c;
    logic [PTR_W-1:0]        front_dec;
    logic [PTR_W-1:0]        front_inc;
    logic [CNT_W-1:0]        ofs;
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]        sum_wrap;
    logic signed [DATA_W-1:0] rdata;

    assign pend_move = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_reg || pend_move;
    assign accept    = in_valid && in_ready;

    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == CNT_FULL);

    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - PTR_W'(1);
    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + PTR_W'(1);

    // back position: front + count for a push, front + count - 1 for a peek
    assign back_c   = (cmd == CMD_PUSH_BACK);
    assign ofs      = back_c ? cnt_reg : cnt_reg - CNT_W'(1);
    assign sum      = SUM_W'(front_reg) + SUM_W'(ofs);
    assign sum_wrap = (sum >= SUM_DEPTH) ? sum - SUM_DEPTH : sum;

    always_comb
    begin
        front_next = front_reg;
        cnt_next   = cnt_reg;
        ok_c       = 1'b0;
        peek_c     = 1'b0;
        mem_ctl    = '0;
        addr_c     = front_reg;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (!is_full)
                begin
                    front_next    = front_dec;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    addr_c        = front_dec;
                    mem_ctl.wr_en = accept;
                    ok_c          = 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (!is_full)
                begin
                    cnt_next      = cnt_reg + CNT_W'(1);
                    addr_c        = sum_wrap[PTR_W-1:0];
                    mem_ctl.wr_en = accept;
                    ok_c          = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (!is_empty)
                begin
                    front_next = front_inc;
                    cnt_next   = cnt_reg - CNT_W'(1);
                    ok_c       = 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (!is_empty)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    ok_c     = 1'b1;
                end
            end
            CMD_PEEK_FRONT:
            begin
                if (!is_empty)
                begin
                    addr_c        = front_reg;
                    mem_ctl.rd_en = accept;
                    peek_c        = 1'b1;
                    ok_c          = 1'b1;
                end
            end
            CMD_PEEK_BACK:
            begin
                if (!is_empty)
                begin
                    addr_c        = sum_wrap[PTR_W-1:0];
                    mem_ctl.rd_en = accept;
                    peek_c        = 1'b1;
                    ok_c          = 1'b1;
                end
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pend_next      = pend_reg;
        pend_ok_next   = pend_ok_reg;
        pend_peek_next = pend_peek_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (pend_move)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            pend_next      = 1'b1;
            pend_ok_next   = ok_c;
            pend_peek_next = peek_c;
            pend_cnt_next  = cnt_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                front_reg <= front_next;
                cnt_reg   <= cnt_next;
            end
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ok_reg   <= pend_ok_next;
        pend_peek_reg <= pend_peek_next;
        pend_cnt_reg  <= pend_cnt_next;
        if (pend_move)
        begin
            ok_reg       <= pend_ok_reg;
            data_out_reg <= pend_peek_reg ? rdata : '0;
            cnt_out_reg  <= pend_cnt_reg;
        end
    end

    deq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (addr_c),
        .wdata (data_in),
        .rdata (rdata)
    );

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign data_out  = data_out_reg;
    assign count     = COUNT_W'(cnt_out_reg);
    assign empty_res = (cnt_out_reg == '0);
    assign full_res  = (cnt_out_reg == CNT_FULL);

endmodule
